>>> rtl/gba_pkg.sv
// Shared constants, codes and helpers of the grouped bitmap allocator.
package gba_pkg;

    localparam int CFG_W   = 14;
    localparam int CFGI_W  = 2;
    localparam int COUNT_W = 18;
    localparam int GFREE_W = 14;
    localparam int WORD_W  = 32;

    localparam logic [GFREE_W-1:0] GROUP_FREE_MAX = 14'h3FFF;

    localparam logic [CFG_W-1:0] BPG_RESET   = 14'd8192;
    localparam logic [4:0]       GCNT_RESET  = 5'd16;

    typedef enum logic [CFGI_W-1:0] {
        CFG_BITS_PER_GROUP = 2'd0,
        CFG_GROUP_COUNT    = 2'd1,
        CFG_INDEX_BASE     = 2'd2,
        CFG_UNUSED         = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_LOAD_WORD  = 2'd0,
        MODE_LOAD_GROUP = 2'd1,
        MODE_SET_TOTAL  = 2'd2,
        MODE_ALLOC      = 2'd3
    } mode_t;

    function automatic logic [4:0] first_zero(input logic [WORD_W-1:0] word);
        logic [4:0] pos;
        pos = 5'd0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

endpackage

>>> rtl/gba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/grouped_bitmap_allocator.sv
// Top level of the grouped first-fit bitmap allocator.
//
// Items enter on a valid/ready channel (mode, group, word_index, word_data,
// count_value); each item gives exactly one result on a valid/ready channel
// (found, alloc_index, total_free). Modes 0 to 2 load a bitmap word, a group
// free count or the total free count; their result passes through the done
// state into the output register. An allocation walks the groups: a group is
// skipped on a zero free count, and each scanned group starts a read and then
// reads its bitmap words one after another from the single RAM read port.
// One item is in work at a time; the next is taken in the same cycle that the
// result turns valid, even while it still waits in the output register.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once.
// After reset the bitmap RAM is zeroed one word a cycle, covering all
// MAX_GROUPS * WORDS_PER_GROUP words (4096 by default); in_ready stays low
// until then. A stalled receiver holds the result; the block then finishes
// at most one further item and waits for the output register to empty.
module grouped_bitmap_allocator #(
    parameter int MAX_GROUPS      = 16,
    parameter int WORDS_PER_GROUP = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [gba_pkg::CFGI_W-1:0]   cfg_index,
    input  logic [gba_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   mode,
    input  logic [3:0]                   group,
    input  logic [7:0]                   word_index,
    input  logic [31:0]                  word_data,
    input  logic [17:0]                  count_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         found,
    output logic [17:0]                  alloc_index,
    output logic [17:0]                  total_free
);

    import gba_pkg::*;

    localparam int DEPTH    = MAX_GROUPS * WORDS_PER_GROUP;
    localparam int AW       = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int WW       = WORDS_PER_GROUP > 1 ? $clog2(WORDS_PER_GROUP) : 1;
    localparam int GI_W     = MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1;
    localparam int GC_W     = $clog2(MAX_GROUPS + 1);
    localparam int MAX_BITS = WORDS_PER_GROUP * 32;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_GROUP = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;

    logic [CFG_W-1:0]       bpg_reg;
    logic [4:0]             gcnt_reg;
    logic                   base_reg;

    logic [GFREE_W-1:0]     gfree_reg [MAX_GROUPS];
    logic [COUNT_W-1:0]     total_reg, total_next;

    logic [GC_W-1:0]        g_reg, g_next;
    logic [GC_W-1:0]        ng_reg, ng_next;
    logic [CFG_W-1:0]       nbits_reg, nbits_next;
    logic [9:0]             nwords_reg, nwords_next;
    logic [WW-1:0]          w_reg, w_next;
    logic [AW-1:0]          gbase_reg, gbase_next;
    logic [COUNT_W-1:0]     offset_reg, offset_next;

    logic                   res_found_reg, res_found_next;
    logic [COUNT_W-1:0]     res_index_reg, res_index_next;

    logic                   out_valid_reg;
    logic                   found_reg;
    logic [COUNT_W-1:0]     alloc_index_reg;
    logic [COUNT_W-1:0]     total_free_reg;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [WORD_W-1:0]      ram_rdata;

    logic                   accept;
    logic                   out_free;
    logic [GI_W-1:0]        gidx;
    logic [GI_W-1:0]        load_gidx;
    logic                   group_ok;
    logic                   word_ok;
    logic [AW-1:0]          load_addr;
    logic [GFREE_W-1:0]     load_count;
    logic [4:0]             zero_bit;
    logic [15:0]            pos;
    logic                   word_full;
    logic                   pos_ok;
    logic                   more_words;
    logic                   alloc_hit;
    logic [16:0]            bpg_ext;
    logic [14:0]            nbits_sum;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == ST_IDLE);
    assign out_free   = !out_valid_reg || out_ready;
    assign gidx       = g_reg[GI_W-1:0];
    assign load_gidx  = GI_W'(group);
    assign group_ok   = 7'(group) < 7'(MAX_GROUPS);
    assign word_ok    = 11'(word_index) < 11'(WORDS_PER_GROUP);
    assign load_addr  = AW'(int'(group) * WORDS_PER_GROUP + int'(word_index));
    assign load_count = (count_value > 18'(GROUP_FREE_MAX)) ? GROUP_FREE_MAX
                                                            : count_value[GFREE_W-1:0];
    assign zero_bit   = first_zero(ram_rdata);
    assign pos        = 16'({w_reg, zero_bit});
    assign word_full  = (ram_rdata == '1);
    assign pos_ok     = pos < 16'(nbits_reg);
    assign more_words = (11'(w_reg) + 11'd1) < 11'(nwords_reg);
    assign alloc_hit  = (state_reg == ST_SCAN) && !word_full && pos_ok;
    assign bpg_ext    = 17'(bpg_reg);
    assign nbits_sum  = 15'(nbits_next) + 15'd31;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpg_reg  <= BPG_RESET;
            gcnt_reg <= GCNT_RESET;
            base_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BITS_PER_GROUP: bpg_reg  <= cfg_data;
                CFG_GROUP_COUNT:    gcnt_reg <= cfg_data[4:0];
                CFG_INDEX_BASE:     base_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Group free counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_GROUPS; i++)
            begin
                gfree_reg[i] <= '0;
            end
        end
        else if (accept && mode == MODE_LOAD_GROUP && group_ok)
        begin
            gfree_reg[load_gidx] <= load_count;
        end
        else if (alloc_hit)
        begin
            gfree_reg[gidx] <= gfree_reg[gidx] - GFREE_W'(1);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        total_next     = total_reg;
        g_next         = g_reg;
        ng_next        = ng_reg;
        nbits_next     = nbits_reg;
        nwords_next    = nwords_reg;
        w_next         = w_reg;
        gbase_next     = gbase_reg;
        offset_next    = offset_reg;
        res_found_next = res_found_reg;
        res_index_next = res_index_reg;
        ram_we         = 1'b0;
        ram_waddr      = gbase_reg + AW'(w_reg);
        ram_wdata      = ram_rdata | (WORD_W'(1) << zero_bit);
        ram_raddr      = gbase_reg + AW'(w_reg);

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_found_next = 1'b0;
                    res_index_next = '0;
                    state_next     = ST_DONE;
                    case (mode)
                        MODE_LOAD_WORD:
                        begin
                            ram_we    = group_ok && word_ok;
                            ram_waddr = load_addr;
                            ram_wdata = word_data;
                        end
                        MODE_SET_TOTAL:
                        begin
                            total_next = count_value;
                        end
                        MODE_ALLOC:
                        begin
                            ng_next     = (7'(gcnt_reg) > 7'(MAX_GROUPS)) ? GC_W'(MAX_GROUPS)
                                                                          : GC_W'(gcnt_reg);
                            nbits_next  = (bpg_ext > 17'(MAX_BITS)) ? CFG_W'(MAX_BITS)
                                                                    : bpg_reg;
                            nwords_next = nbits_sum[14:5];
                            g_next      = '0;
                            gbase_next  = '0;
                            offset_next = '0;
                            w_next      = '0;
                            state_next  = ST_GROUP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_GROUP:
            begin
                w_next = '0;
                if (g_reg >= ng_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (gfree_reg[gidx] == '0 || nwords_reg == '0)
                begin
                    g_next      = g_reg + GC_W'(1);
                    gbase_next  = gbase_reg + AW'(WORDS_PER_GROUP);
                    offset_next = offset_reg + COUNT_W'(nbits_reg);
                end
                else
                begin
                    ram_raddr  = gbase_reg;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (word_full && more_words)
                begin
                    w_next    = w_reg + WW'(1);
                    ram_raddr = gbase_reg + AW'(w_reg + WW'(1));
                end
                else if (alloc_hit)
                begin
                    ram_we         = 1'b1;
                    total_next     = (total_reg != '0) ? total_reg - COUNT_W'(1) : total_reg;
                    res_found_next = 1'b1;
                    res_index_next = offset_reg + COUNT_W'(pos) + COUNT_W'(base_reg);
                    state_next     = ST_DONE;
                end
                else
                begin
                    g_next      = g_reg + GC_W'(1);
                    gbase_next  = gbase_reg + AW'(WORDS_PER_GROUP);
                    offset_next = offset_reg + COUNT_W'(nbits_reg);
                    state_next  = ST_GROUP;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            total_reg   <= total_next;
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        g_reg         <= g_next;
        ng_reg        <= ng_next;
        nbits_reg     <= nbits_next;
        nwords_reg    <= nwords_next;
        w_reg         <= w_next;
        gbase_reg     <= gbase_next;
        offset_reg    <= offset_next;
        res_found_reg <= res_found_next;
        res_index_reg <= res_index_next;
        if (state_reg == ST_DONE && out_free)
        begin
            found_reg       <= res_found_reg;
            alloc_index_reg <= res_index_reg;
            total_free_reg  <= total_reg;
        end
    end

    gba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign alloc_index = alloc_index_reg;
    assign total_free  = total_free_reg;

    a_fail_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (alloc_index == '0))
        else $error("failed allocation reports a nonzero index");

    a_hit_group_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_hit |-> (gfree_reg[gidx] != '0))
        else $error("allocation taken from a group with no free count");

    a_scan_write_has_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && ram_we) |-> (ram_rdata != '1))
        else $error("bitmap write-back from a full word");

    a_total_not_raised: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_hit |=> (total_reg <= $past(total_reg)))
        else $error("total free count grew on an allocation");

endmodule
